/* rtl/core/trapezoid_position_servo_top_defines.svh */
// Assertion macros for the trapezoid position servo checker.
// Used by tps_checker.sv; expects clk_i and rst_ni in the including scope.
`ifndef TRAPEZOID_POSITION_SERVO_TOP_DEFINES_SVH
`define TRAPEZOID_POSITION_SERVO_TOP_DEFINES_SVH

// clocked, disabled during reset
`define TPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tps_checker: property failed");

// only checked while a response transaction is offered
`define TPS_ASSERT_RSP(name, prop) \
  `TPS_ASSERT(name, rsp_valid_i |-> (prop))

`endif

/* rtl/core/tps_pkg.sv */
// Package of the trapezoid position servo: widths, reset values, codes, types.
// No dependencies; used by every other file of the block but the defines header.
`default_nettype none

package tps_pkg;

  localparam int SCALE_LOG2 = 4;
  localparam int SCALE      = 1 << SCALE_LOG2;

  localparam int ACT_W     = 3;
  localparam int POS_W     = 32;
  localparam int GAIN_W    = 10;
  localparam int DLIM_W    = 8;
  localparam int VMAX_W    = 24;
  localparam int ACC_W     = 16;
  localparam int STEP_W    = 16;
  localparam int DRV_W     = 9;
  localparam int STALL_W   = 2;
  localparam int WIDE_W    = 48;
  localparam int LIM_W     = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam int MUL_AW = 34;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam int DIV_NW = $clog2(2 * SCALE * ((1 << DLIM_W) - 1) + 1);

  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(10);
  localparam logic [DLIM_W-1:0] DLIM_RST = DLIM_W'(255);
  localparam logic [VMAX_W-1:0] VMAX_RST = VMAX_W'(1000);
  localparam logic [ACC_W-1:0]  ACC_RST  = ACC_W'(10);
  localparam logic [LIM_W-1:0]  LIM_RST  = LIM_W'(2 * SCALE * 255 / 10);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_TARGET = 3'd1,
    ACT_SOFT   = 3'd2,
    ACT_ESTOP  = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 2'd0,
    REG_DLIM = 2'd1,
    REG_VMAX = 2'd2,
    REG_ACC  = 2'd3
  } reg_e;

  typedef enum logic [STALL_W-1:0] {
    STALL_NONE = 2'd0,
    STALL_POS  = 2'd1,
    STALL_NEG  = 2'd2
  } stall_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRK1,
    ST_BRK2,
    ST_SPD,
    ST_STEP,
    ST_SETP,
    ST_ERR,
    ST_DRV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/tps_if.sv */
// Channel interfaces of the trapezoid position servo: command, response, config.
// Depends on tps_pkg.
`default_nettype none

interface tps_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [tps_pkg::ACT_W-1:0]         action;
  logic signed [tps_pkg::POS_W-1:0]  position;
  modport source (output valid, action, position, input ready);
  modport sink   (input valid, action, position, output ready);
endinterface

interface tps_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [tps_pkg::DRV_W-1:0]  drive;
  logic [tps_pkg::STALL_W-1:0]       stall_res;
  logic signed [tps_pkg::STEP_W-1:0] speed_step;
  modport source (output valid, drive, stall_res, speed_step, input ready);
  modport sink   (input valid, drive, stall_res, speed_step, output ready);
endinterface

interface tps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tps_pkg::CFG_IDX_W-1:0]     index;
  logic [tps_pkg::CFG_DAT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tps_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on tps_pkg; ends early once the remaining multiplier bits are zero.
`default_nettype none

module tps_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tps_pkg::mul_req_t req_i,
  output tps_pkg::mul_rsp_t rsp_o
);
  import tps_pkg::*;

  logic [MUL_PW-1:0] a_q, a_d, p_q, p_d;
  logic [MUL_BW-1:0] b_q, b_d;
  logic              busy_q, busy_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    busy_d = busy_q;
    if (req_i.start) begin
      a_d    = MUL_PW'(req_i.a);
      b_d    = req_i.b;
      p_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) begin
          p_d = p_q + a_q;
        end
        a_d = a_q << 1;
        b_d = b_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign rsp_o.done = busy_q && (b_q == '0);
  assign rsp_o.prod = p_q;

endmodule

`default_nettype wire

/* rtl/core/tps_div.sv */
// Restoring divider, one quotient bit per cycle, for the stall limit.
// Depends on tps_pkg.
`default_nettype none

module tps_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tps_pkg::DIV_NW-1:0] num_i,
  input  logic [tps_pkg::GAIN_W-1:0] den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [tps_pkg::DIV_NW-1:0] quo_o
);
  import tps_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [GAIN_W-1:0] rem_q, den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [GAIN_W:0]   sh;
  logic              fit;

  assign sh  = {rem_q, quo_q[DIV_NW-1]};
  assign fit = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fit ? GAIN_W'(sh - {1'b0, den_q}) : sh[GAIN_W-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], fit};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* rtl/core/trapezoid_position_servo_top.sv */
// Trapezoid position servo: profile sequencer, serial multiplier and divider.
// Depends on tps_pkg, tps_if, tps_mul, tps_div.
//
// Usage:
//   cmd_i carries an action and a position. A tick (measured position) runs
//   the speed profile and the proportional loop and gives one response
//   transaction on rsp_o (drive, stall_res, speed_step). Set target, soft
//   stop, emergency stop and clear take effect in the cycle they are accepted
//   and give no response.
//   cfg_i writes gain, drive_limit, speed_limit, accel_step; always ready.
//   A write of gain or drive_limit recomputes the stall limit with the
//   serial divider, during which cmd_i is not ready.
//   A tick takes four serial multiplies on one shared shift-and-add unit,
//   each ending once its remaining multiplier bits are zero, plus four
//   steps (speed decision, setpoint, error, output) before the response.
//   cmd_i is ready again when the response is loaded into the output
//   register; a stalled receiver holds a new tick in its last step only.
//   Reset clears the motion state and loads the register reset values.
`default_nettype none

module trapezoid_position_servo_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  tps_cmd_if.sink   cmd_i,
  tps_rsp_if.source rsp_o,
  tps_cfg_if.sink   cfg_i
);
  import tps_pkg::*;

  localparam int SL = SCALE_LOG2;
  localparam logic signed [STEP_W-1:0] STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};
  localparam logic signed [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};

  state_e state_q, state_d;

  logic [GAIN_W-1:0] gain_q;
  logic [DLIM_W-1:0] dlim_q;
  logic [VMAX_W-1:0] vmax_q;
  logic [ACC_W-1:0]  acc_q;
  logic [LIM_W-1:0]  lim_q;

  logic signed [WIDE_W-1:0] ss_q, st_q;
  logic [WIDE_W-1:0]        brake_q;
  logic signed [STEP_W-1:0] step_q, s1_q;
  logic signed [POS_W-1:0]  pos_q;
  logic signed [MUL_AW-1:0] sa_q;
  logic                     chk_q, dneg_q;
  logic [STALL_W-1:0]       flag_q;
  logic signed [DRV_W-1:0]  drv_q;

  logic                     rsp_valid_q;
  logic signed [DRV_W-1:0]  rsp_drive_q;
  logic [STALL_W-1:0]       rsp_stall_q;
  logic signed [STEP_W-1:0] rsp_step_q;

  logic div_go_q, div_busy, div_done;
  logic [DIV_NW-1:0] div_quo;
  logic div_pend, cmd_acc, cfg_acc, out_free;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // datapath terms
  logic signed [STEP_W:0]   step_x, s1_x;
  logic [STEP_W:0]          step_mag, s1_mag;
  logic signed [WIDE_W:0]   delta, err;
  logic [WIDE_W:0]          dabs, eabs;
  logic                     go_move, up;
  logic signed [STEP_W-1:0] s1, step_new;
  logic                     chk;
  logic [32:0]              pm, p1, kacc, pp;
  logic                     over1, over2;
  logic [1:0]               k;
  logic signed [WIDE_W-1:0] spos, ss_new, adj, qf;
  logic signed [WIDE_W-1:0] cmd_spos;
  logic signed [POS_W-1:0]  q32;
  logic signed [POS_W:0]    dd;
  logic [POS_W:0]           dd_abs;
  logic [STALL_W-1:0]       flag_new;
  logic [41:0]              hh;
  logic [DLIM_W-1:0]        mag8;
  logic signed [DRV_W-1:0]  drv_new;

  assign div_pend    = div_go_q | div_busy | div_done;
  assign cmd_i.ready = (state_q == ST_IDLE) && !div_pend;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign cmd_spos    = {{(WIDE_W-POS_W-SL){cmd_i.position[POS_W-1]}}, cmd_i.position,
                        {SL{1'b0}}};

  tps_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  tps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (DIV_NW'({dlim_q, {(SL+1){1'b0}}})),
    .den_i   (gain_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // speed decision
  always_comb begin
    step_x   = {step_q[STEP_W-1], step_q};
    step_mag = step_x[STEP_W] ? 17'(-step_x) : 17'(step_x);
    delta    = {st_q[WIDE_W-1], st_q} - {ss_q[WIDE_W-1], ss_q};
    dabs     = delta[WIDE_W] ? 49'(-delta) : 49'(delta);
    go_move  = dabs >= {1'b0, brake_q};
    up       = !delta[WIDE_W];
    if (go_move) begin
      if (up) begin
        s1 = (step_q == STEP_MAX) ? step_q : step_q + 16'sd1;
      end else begin
        s1 = (step_q == STEP_MIN) ? step_q : step_q - 16'sd1;
      end
    end else if (step_q > 16'sd0) begin
      s1 = step_q - 16'sd1;
    end else if (step_q < 16'sd0) begin
      s1 = step_q + 16'sd1;
    end else begin
      s1 = '0;
    end
    chk    = go_move && (up ? (s1 > 16'sd0) : (s1 < 16'sd0));
    s1_x   = {s1[STEP_W-1], s1};
    s1_mag = s1_x[STEP_W] ? 17'(-s1_x) : 17'(s1_x);
  end

  // speed cap and step product
  always_comb begin
    pp    = mul_rsp.prod[32:0];
    p1    = pp - 33'(acc_q);
    over1 = pp > 33'(vmax_q);
    over2 = p1 > 33'(vmax_q);
    k     = !chk_q ? 2'd0 : (!over1 ? 2'd0 : (over2 ? 2'd2 : 2'd1));
    case (k)
      2'd1:    kacc = 33'(acc_q);
      2'd2:    kacc = 33'({acc_q, 1'b0});
      default: kacc = '0;
    endcase
    pm       = pp - kacc;
    step_new = (s1_q > 16'sd0) ? s1_q - 16'(k) : s1_q + 16'(k);
  end

  // setpoint advance and stall clamp
  always_comb begin
    spos = {{(WIDE_W-POS_W-SL){pos_q[POS_W-1]}}, pos_q, {SL{1'b0}}};
    err  = {ss_q[WIDE_W-1], ss_q} - {spos[WIDE_W-1], spos};
    eabs = err[WIDE_W] ? 49'(-err) : 49'(err);
    if (eabs < 49'(lim_q)) begin
      ss_new   = ss_q + {{(WIDE_W-MUL_AW){sa_q[MUL_AW-1]}}, sa_q};
      flag_new = STALL_NONE;
    end else if (!err[WIDE_W]) begin
      ss_new   = spos + WIDE_W'(lim_q);
      flag_new = STALL_POS;
    end else begin
      ss_new   = spos - WIDE_W'(lim_q);
      flag_new = STALL_NEG;
    end
  end

  // setpoint to position units, error and drive
  always_comb begin
    adj = ss_q + (ss_q[WIDE_W-1] ? WIDE_W'(SCALE - 1) : '0);
    qf  = adj >>> SL;
    if (qf > 48'sh0000_7FFF_FFFF) begin
      q32 = 32'sh7FFF_FFFF;
    end else if (qf < -48'sh0000_8000_0000) begin
      q32 = 32'sh8000_0000;
    end else begin
      q32 = qf[POS_W-1:0];
    end
    dd      = {q32[POS_W-1], q32} - {pos_q[POS_W-1], pos_q};
    dd_abs  = dd[POS_W] ? 33'(-dd) : 33'(dd);
    hh      = mul_rsp.prod[42:1];
    mag8    = (hh > 42'(dlim_q)) ? dlim_q : hh[DLIM_W-1:0];
    drv_new = dneg_q ? DRV_W'(-{1'b0, mag8}) : DRV_W'({1'b0, mag8});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_acc && cmd_i.action == ACT_TICK) state_d = ST_BRK1;
      ST_BRK1: if (mul_rsp.done) state_d = ST_BRK2;
      ST_BRK2: if (mul_rsp.done) state_d = ST_SPD;
      ST_SPD:  state_d = ST_STEP;
      ST_STEP: if (mul_rsp.done) state_d = ST_SETP;
      ST_SETP: state_d = ST_ERR;
      ST_ERR:  state_d = ST_DRV;
      ST_DRV:  if (mul_rsp.done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mul_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_acc && cmd_i.action == ACT_TICK) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(step_mag + 17'd2);
          mul_req.b     = step_mag + 17'd1;
        end
      end
      ST_BRK1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.prod[MUL_AW-1:0];
          mul_req.b     = MUL_BW'(acc_q);
        end
      end
      ST_SPD: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(acc_q);
        mul_req.b     = s1_mag;
      end
      ST_ERR: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(dd_abs);
        mul_req.b     = MUL_BW'(gain_q);
      end
      default: mul_req = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= GAIN_RST;
      dlim_q      <= DLIM_RST;
      vmax_q      <= VMAX_RST;
      acc_q       <= ACC_RST;
      lim_q       <= LIM_RST;
      div_go_q    <= 1'b0;
      ss_q        <= '0;
      st_q        <= '0;
      step_q      <= '0;
      brake_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= 1'b0;
      if (cfg_acc) begin
        case (cfg_i.index)
          REG_GAIN: gain_q <= cfg_i.data[GAIN_W-1:0];
          REG_DLIM: dlim_q <= cfg_i.data[DLIM_W-1:0];
          REG_VMAX: vmax_q <= cfg_i.data[VMAX_W-1:0];
          REG_ACC:  acc_q  <= cfg_i.data[ACC_W-1:0];
          default:  ;
        endcase
        div_go_q <= (cfg_i.index == REG_GAIN) || (cfg_i.index == REG_DLIM);
      end
      if (div_done) begin
        lim_q <= (gain_q == '0) ? '1 : LIM_W'(div_quo);
      end
      if (cmd_acc) begin
        case (cmd_i.action)
          ACT_TARGET: st_q <= cmd_spos;
          ACT_SOFT:   st_q <= (step_q > 16'sd0) ? ss_q + brake_q : ss_q - brake_q;
          ACT_ESTOP: begin
            st_q   <= cmd_spos;
            step_q <= '0;
          end
          ACT_CLEAR: begin
            ss_q   <= '0;
            st_q   <= '0;
            step_q <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == ST_BRK2 && mul_rsp.done) begin
        brake_q <= WIDE_W'(mul_rsp.prod[48:1]);
      end
      if (state_q == ST_STEP && mul_rsp.done) begin
        step_q <= step_new;
      end
      if (state_q == ST_SETP) begin
        ss_q <= ss_new;
      end
      if (state_q == ST_OUT && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      pos_q <= cmd_i.position;
    end
    if (state_q == ST_SPD) begin
      s1_q  <= s1;
      chk_q <= chk;
    end
    if (state_q == ST_STEP && mul_rsp.done) begin
      sa_q <= s1_q[STEP_W-1] ? MUL_AW'(-{1'b0, pm}) : MUL_AW'({1'b0, pm});
    end
    if (state_q == ST_SETP) begin
      flag_q <= flag_new;
    end
    if (state_q == ST_ERR) begin
      dneg_q <= dd[POS_W];
    end
    if (state_q == ST_DRV && mul_rsp.done) begin
      drv_q <= drv_new;
    end
    if (state_q == ST_OUT && out_free) begin
      rsp_drive_q <= drv_q;
      rsp_stall_q <= flag_q;
      rsp_step_q  <= step_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.drive      = rsp_drive_q;
  assign rsp_o.stall_res  = rsp_stall_q;
  assign rsp_o.speed_step = rsp_step_q;

endmodule

`default_nettype wire

/* rtl/core/tps_checker.sv */
// Port-level checker of the trapezoid position servo, bound to the top level.
// Depends on tps_pkg and trapezoid_position_servo_top_defines.svh.
`default_nettype none

`include "trapezoid_position_servo_top_defines.svh"

module tps_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  logic                        cmd_ready_i,
  input  logic [tps_pkg::ACT_W-1:0]   cmd_action_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  logic [tps_pkg::DRV_W-1:0]   rsp_drive_i,
  input  logic [tps_pkg::STALL_W-1:0] rsp_stall_i
);
  import tps_pkg::*;

  `TPS_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
  `TPS_ASSERT(a_tick_busy, cmd_valid_i && cmd_ready_i && cmd_action_i == ACT_TICK |=> !cmd_ready_i)
  `TPS_ASSERT_RSP(a_stall_code, rsp_stall_i == STALL_NONE || rsp_stall_i == STALL_POS || rsp_stall_i == STALL_NEG)
  `TPS_ASSERT_RSP(a_drive_range, rsp_drive_i != 9'h100)

endmodule

bind trapezoid_position_servo_top tps_checker u_tps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .cmd_action_i (cmd_i.action),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_drive_i  (rsp_o.drive),
  .rsp_stall_i  (rsp_o.stall_res)
);

`default_nettype wire
